/* hw/rtl/fno_pkg.sv */
// fno_pkg: shared widths, constants and types for the frequency-to-note unit.
// No dependencies; the interfaces and every RTL module import it.
`default_nettype none

package fno_pkg;

  // Payload widths
  localparam int unsigned FREQ_W  = 20;
  localparam int unsigned REF_W   = 18;
  localparam int unsigned NOTE_W  = 4;
  localparam int unsigned OCT_W   = 5;

  // log2 datapath
  localparam int unsigned LOG_FRAC_BITS_DEF = 16;
  localparam int unsigned EXP_W   = $clog2(FREQ_W);
  localparam int unsigned MANT_W  = 31;            // Q1.30 mantissa

  // Reference register
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(112640);   // 440 Hz in Q10.8

  // APB port
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  typedef enum logic {
    REG_REFERENCE_FREQ = 1'b0
  } reg_idx_t;

  // Musical constants
  localparam int unsigned SEMIS    = 12;
  localparam int unsigned A_INDEX  = 9;
  localparam int          A_OCTAVE = 4;
  localparam int          OCT_MAX  = 15;
  localparam int          OCT_MIN  = -16;

  // Semitone distance never exceeds 12 per bit of input width
  localparam int unsigned IDX_OFF  = SEMIS * FREQ_W;              // multiple of 12
  localparam int unsigned NMAG_W   = $clog2(IDX_OFF + 1);
  localparam int unsigned U_W      = $clog2(A_INDEX + 2 * IDX_OFF + 1);

  // floor(u/12) as (u*683) >> 13, exact for u below 512
  localparam int unsigned RECIP    = 683;
  localparam int unsigned RECIP_W  = 10;
  localparam int unsigned RECIP_SH = 13;
  localparam int unsigned PROD_W   = U_W + RECIP_W;
  localparam int unsigned Q_W      = PROD_W - RECIP_SH;

  // Per-stage control travelling with the data
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/fno_if.sv */
// fno_if: valid/ready channel interfaces for frequency beats and note beats.
// Depends on fno_pkg for payload widths.
`default_nettype none

interface fno_in_if;
  import fno_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;

  modport source (output valid, output frequency, input ready);
  modport sink   (input valid, input frequency, output ready);
endinterface

interface fno_out_if;
  import fno_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [NOTE_W-1:0]       note;
  logic signed [OCT_W-1:0] octave;
  logic                    valid_res;

  modport source (output valid, output note, output octave, output valid_res, input ready);
  modport sink   (input valid, input note, input octave, input valid_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/frequency_to_note_octave_unit.sv */
// frequency_to_note_octave_unit: top level with the APB register, the log2
// pipeline and the note pipeline. Depends on fno_pkg, fno_if and both pipes.
`default_nettype none

// Takes one frequency beat per cycle and returns the nearest equal-tempered
// note and octave relative to the A4 reference register. The pipeline has
// one normalise stage, one squaring stage per log2 fraction bit, and four
// stages for the log difference, the semitone scaling, rounding and the
// divide-by-twelve, the last of which is the output register. The whole
// pipeline advances together, so a stalled output beat holds every stage;
// throughput is one beat per cycle while the sink takes results. A zero
// frequency returns valid_res low with note and octave zero, and a
// reference of zero is treated as one. Write the reference only while
// no beats are in flight.
module frequency_to_note_octave_unit #(
  parameter int unsigned LOG_FRAC_BITS = fno_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fno_in_if.sink                       in_chan,
  fno_out_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fno_pkg::APB_AW-1:0]   paddr,
  input  logic [fno_pkg::APB_DW-1:0]   pwdata,
  output logic [fno_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import fno_pkg::*;

  localparam int unsigned ACC_W = EXP_W + LOG_FRAC_BITS;

  logic [REF_W-1:0]  ref_r;
  logic              en;
  logic              reg_hit;
  ctl_t              in_ctl;
  logic [FREQ_W-1:0] xa;
  logic [FREQ_W-1:0] xb;
  ctl_t              log_ctl;
  logic [ACC_W-1:0]  la;
  logic [ACC_W-1:0]  lb;
  logic              out_vld;

  // Register decode
  assign reg_hit = (reg_idx_t'(paddr[2]) == REG_REFERENCE_FREQ);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(ref_r) : '0;

  // Hold the reference; write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      ref_r <= pwdata[REF_W-1:0];
    end
  end

  // Advance everything unless the output beat is stalled
  assign en            = !out_vld || out_chan.ready;
  assign in_chan.ready = en;

  // Zero inputs are taken as one for the log
  assign in_ctl.valid = in_chan.valid;
  assign in_ctl.zero  = (in_chan.frequency == '0);
  assign xa = in_ctl.zero ? FREQ_W'(1) : in_chan.frequency;
  assign xb = (ref_r == '0) ? FREQ_W'(1) : FREQ_W'(ref_r);

  fno_log2_pipe #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (in_ctl),
    .xa_i  (xa),
    .xb_i  (xb),
    .ctl_o (log_ctl),
    .la_o  (la),
    .lb_o  (lb)
  );

  fno_note_pipe #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_note (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl_i       (log_ctl),
    .la_i        (la),
    .lb_i        (lb),
    .valid_o     (out_vld),
    .note_o      (out_chan.note),
    .octave_o    (out_chan.octave),
    .valid_res_o (out_chan.valid_res)
  );

  assign out_chan.valid = out_vld;

endmodule

`default_nettype wire

/* hw/rtl/fno_log2_pipe.sv */
// fno_log2_pipe: two-lane fixed-point log2, one normalise stage then one
// squaring stage per fraction bit. Depends on fno_pkg.
`default_nettype none

module fno_log2_pipe #(
  parameter int unsigned LOG_FRAC_BITS = fno_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  fno_pkg::ctl_t                                   ctl_i,
  input  logic [fno_pkg::FREQ_W-1:0]                      xa_i,
  input  logic [fno_pkg::FREQ_W-1:0]                      xb_i,
  output fno_pkg::ctl_t                                   ctl_o,
  output logic [fno_pkg::EXP_W+LOG_FRAC_BITS-1:0]         la_o,
  output logic [fno_pkg::EXP_W+LOG_FRAC_BITS-1:0]         lb_o
);
  import fno_pkg::*;

  localparam int unsigned F    = LOG_FRAC_BITS;
  localparam int unsigned ACC_W = EXP_W + F;
  localparam int unsigned PAD_W = MANT_W - FREQ_W;

  ctl_t               ctl_r [0:F];
  logic [MANT_W-1:0]  ma_r  [0:F];
  logic [MANT_W-1:0]  mb_r  [0:F];
  logic [ACC_W-1:0]   acca_r[0:F];
  logic [ACC_W-1:0]   accb_r[0:F];

  logic [MANT_W-1:0]  ma_nxt  [0:F];
  logic [MANT_W-1:0]  mb_nxt  [0:F];
  logic [ACC_W-1:0]   acca_nxt[0:F];
  logic [ACC_W-1:0]   accb_nxt[0:F];

  // Index of the highest set bit
  function automatic logic [EXP_W-1:0] msb_idx(input logic [FREQ_W-1:0] x);
    logic [EXP_W-1:0] r;
    r = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (x[i]) r = EXP_W'(i);
    end
    return r;
  endfunction

  // Shift the leading one up to bit 30
  function automatic logic [MANT_W-1:0] norm(input logic [FREQ_W-1:0] x,
                                             input logic [EXP_W-1:0]  e);
    logic [MANT_W-1:0] w;
    w = {x, {PAD_W{1'b0}}};
    return w << (EXP_W'(FREQ_W - 1) - e);
  endfunction

  // Square the mantissa, take one fraction bit, renormalise
  function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    sq = m * m;
    t  = sq[2*MANT_W-1:MANT_W-1];
    // returns {bit, next mantissa}
    return t[MANT_W] ? {1'b1, t[MANT_W:1]} : {1'b0, t[MANT_W-1:0]};
  endfunction

  // Stage 0 from the inputs, stage k+1 from stage k
  always_comb begin
    logic [EXP_W-1:0] ea;
    logic [EXP_W-1:0] eb;
    logic [MANT_W:0]  ra;
    logic [MANT_W:0]  rb;
    ea          = msb_idx(xa_i);
    eb          = msb_idx(xb_i);
    ma_nxt[0]   = norm(xa_i, ea);
    mb_nxt[0]   = norm(xb_i, eb);
    acca_nxt[0] = ACC_W'(ea);
    accb_nxt[0] = ACC_W'(eb);
    for (int k = 0; k < F; k++) begin
      ra            = sq_step(ma_r[k]);
      rb            = sq_step(mb_r[k]);
      ma_nxt[k+1]   = ra[MANT_W-1:0];
      mb_nxt[k+1]   = rb[MANT_W-1:0];
      acca_nxt[k+1] = {acca_r[k][ACC_W-2:0], ra[MANT_W]};
      accb_nxt[k+1] = {accb_r[k][ACC_W-2:0], rb[MANT_W]};
    end
  end

  // Advance control on enable; cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= F; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int k = 0; k < F; k++) ctl_r[k+1] <= ctl_r[k];
    end
  end

  // Advance payload on enable
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= F; k++) begin
        ma_r[k]   <= ma_nxt[k];
        mb_r[k]   <= mb_nxt[k];
        acca_r[k] <= acca_nxt[k];
        accb_r[k] <= accb_nxt[k];
      end
    end
  end

  assign ctl_o = ctl_r[F];
  assign la_o  = acca_r[F];
  assign lb_o  = accb_r[F];

endmodule

`default_nettype wire

/* hw/rtl/fno_note_pipe.sv */
// fno_note_pipe: log difference to semitones, rounding, then note and octave.
// Four register stages, the last one is the output register. Depends on fno_pkg.
`default_nettype none

module fno_note_pipe #(
  parameter int unsigned LOG_FRAC_BITS = fno_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  fno_pkg::ctl_t                             ctl_i,
  input  logic [fno_pkg::EXP_W+LOG_FRAC_BITS-1:0]   la_i,
  input  logic [fno_pkg::EXP_W+LOG_FRAC_BITS-1:0]   lb_i,
  output logic                                      valid_o,
  output logic [fno_pkg::NOTE_W-1:0]                note_o,
  output logic signed [fno_pkg::OCT_W-1:0]          octave_o,
  output logic                                      valid_res_o
);
  import fno_pkg::*;

  localparam int unsigned F     = LOG_FRAC_BITS;
  localparam int unsigned ACC_W = EXP_W + F;
  localparam int unsigned D_W   = ACC_W + 1;
  localparam int unsigned S_W   = ACC_W + 5;
  localparam int unsigned OW_W  = Q_W + 2;

  ctl_t                    c1_r, c2_r, c3_r;
  logic signed [D_W-1:0]   diff_r;
  logic                    neg_r;
  logic [S_W-1:0]          mag_r;
  logic [U_W-1:0]          u_r;
  logic                    out_vld_r;
  logic [NOTE_W-1:0]       note_r;
  logic signed [OCT_W-1:0] oct_r;
  logic                    vres_r;

  logic signed [D_W-1:0]   diff_nxt;
  logic signed [S_W-1:0]   s_w;
  logic                    neg_nxt;
  logic [S_W-1:0]          mag_nxt;
  logic [S_W-1:0]          rnd_w;
  logic [NMAG_W-1:0]       n_w;
  logic [U_W-1:0]          u_nxt;
  logic [PROD_W-1:0]       prod_w;
  logic [Q_W-1:0]          q_w;
  logic [U_W-1:0]          rem_w;
  logic signed [OW_W-1:0]  oct_w;
  logic [NOTE_W-1:0]       note_nxt;
  logic signed [OCT_W-1:0] oct_nxt;

  // Stage 1: log difference
  assign diff_nxt = $signed({1'b0, la_i}) - $signed({1'b0, lb_i});

  // Stage 2: times twelve, split into sign and magnitude
  assign s_w     = (S_W'(diff_r) <<< 3) + (S_W'(diff_r) <<< 2);
  assign neg_nxt = s_w[S_W-1];
  assign mag_nxt = neg_nxt ? S_W'(-s_w) : S_W'(s_w);

  // Stage 3: round half away from zero, bias the index to stay positive
  assign rnd_w = mag_r + (S_W'(1) << (F - 1));
  assign n_w   = rnd_w[F +: NMAG_W];
  assign u_nxt = neg_r ? U_W'(A_INDEX + IDX_OFF) - U_W'(n_w)
                       : U_W'(A_INDEX + IDX_OFF) + U_W'(n_w);

  // Stage 4: divide by twelve through the reciprocal, saturate the octave
  assign prod_w = PROD_W'(u_r) * PROD_W'(RECIP);
  assign q_w    = prod_w[PROD_W-1:RECIP_SH];
  assign rem_w  = u_r - (U_W'(q_w) << 3) - (U_W'(q_w) << 2);
  assign oct_w  = $signed({2'b00, q_w}) + OW_W'(A_OCTAVE - int'(FREQ_W));

  always_comb begin
    note_nxt = rem_w[NOTE_W-1:0];
    priority if (oct_w > OW_W'(OCT_MAX)) begin
      oct_nxt = OCT_W'(OCT_MAX);
    end else if (oct_w < OW_W'(OCT_MIN)) begin
      oct_nxt = OCT_W'(OCT_MIN);
    end else begin
      oct_nxt = oct_w[OCT_W-1:0];
    end
    // zero frequency gives an all-zero result
    if (c3_r.zero) begin
      note_nxt = '0;
      oct_nxt  = '0;
    end
  end

  // Control: advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r      <= '0;
      c2_r      <= '0;
      c3_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      c1_r      <= ctl_i;
      c2_r      <= c1_r;
      c3_r      <= c2_r;
      out_vld_r <= c3_r.valid;
    end
  end

  // Payload: advance on enable
  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      neg_r  <= neg_nxt;
      mag_r  <= mag_nxt;
      u_r    <= u_nxt;
      note_r <= note_nxt;
      oct_r  <= oct_nxt;
      vres_r <= ~c3_r.zero;
    end
  end

  assign valid_o     = out_vld_r;
  assign note_o      = note_r;
  assign octave_o    = oct_r;
  assign valid_res_o = vres_r;

endmodule

`default_nettype wire

/* tb/fno_note_checker.sv */
// fno_note_checker: watches the frequency, note and register ports of the
// frequency-to-note unit, predicts each note beat and compares it.
// Depends on fno_pkg and the fno_in_if / fno_out_if channel interfaces.
module fno_note_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  fno_in_if                          in_mon,
  fno_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [fno_pkg::APB_AW-1:0] paddr,
  input  logic [fno_pkg::APB_DW-1:0] pwdata,
  output int                         fail_count,
  output int                         pending
);
  import fno_pkg::*;

  localparam int FRAC       = int'(LOG_FRAC_BITS_DEF);
  localparam int PRINT_CAP  = 30;

  typedef struct packed {
    logic [NOTE_W-1:0]       note;
    logic signed [OCT_W-1:0] octave;
    logic                    valid_res;
  } note_beat_t;

  note_beat_t       notes_due[$];
  logic [REF_W-1:0] a4_ref;
  int               miss_total;

  // log2 of an integer, integer part from the top set bit, fraction bits by
  // repeated squaring of a Q1.30 mantissa, truncated
  function automatic longint log2_fixed(input longint unsigned x);
    int                msb;
    longint unsigned   mant;
    longint            acc;
    if (x == 0) x = 1;
    msb = 0;
    for (int b = 0; b < 64; b++) begin
      if (x[b]) msb = b;
    end
    mant = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
    acc = longint'(msb);
    repeat (FRAC) begin
      mant = (mant * mant) >> 30;
      acc = acc * 2;
      if (mant >= (64'd1 << 31)) begin
        acc = acc + 1;
        mant = mant >> 1;
      end
    end
    return acc;
  endfunction

  // nearest equal-tempered note for one frequency beat
  function automatic note_beat_t predict_note(input logic [FREQ_W-1:0] freq,
                                              input logic [REF_W-1:0] a4);
    note_beat_t res;
    longint     semis_fx, steps, idx, pc, oct, half;
    res = '0;
    if (freq == 0) return res;
    half = longint'(1) << (FRAC - 1);
    semis_fx = longint'(SEMIS) * (log2_fixed(freq) - log2_fixed(a4));
    if (semis_fx >= 0) steps = (semis_fx + half) >> FRAC;
    else steps = -((-semis_fx + half) >> FRAC);
    idx = longint'(A_INDEX) + steps;
    pc = idx % longint'(SEMIS);
    if (pc < 0) pc = pc + longint'(SEMIS);
    oct = longint'(A_OCTAVE) + (idx - pc) / longint'(SEMIS);
    // clamp the octave, the pitch class stands
    if (oct > longint'(OCT_MAX)) oct = longint'(OCT_MAX);
    if (oct < longint'(OCT_MIN)) oct = longint'(OCT_MIN);
    res.note      = NOTE_W'(pc);
    res.octave    = OCT_W'(oct);
    res.valid_res = 1'b1;
    return res;
  endfunction

  task automatic report_miss(input string what, input int got, input int wanted);
    if (miss_total < PRINT_CAP)
      $display("%0t: note beat mismatch on %s: got %0d, expected %0d",
               $time, what, got, wanted);
    miss_total++;
  endtask

  // compare result beats, queue predictions, track the reference register
  always @(posedge clk) begin
    note_beat_t seen, want;
    if (!rst_n) begin
      a4_ref = REF_RESET;
      notes_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen = '{note: out_mon.note, octave: out_mon.octave,
                 valid_res: out_mon.valid_res};
        if (notes_due.size() == 0) begin
          report_miss("unexpected beat", int'(seen.note), -1);
        end else begin
          want = notes_due.pop_front();
          if (seen.note != want.note)
            report_miss("note", int'(seen.note), int'(want.note));
          if (seen.octave != want.octave)
            report_miss("octave", int'(seen.octave), int'(want.octave));
          if (seen.valid_res != want.valid_res)
            report_miss("valid_res", int'(seen.valid_res), int'(want.valid_res));
        end
      end
      if (in_mon.valid && in_mon.ready)
        notes_due.push_back(predict_note(in_mon.frequency, a4_ref));
      // only index zero is mapped, other writes are dropped
      if (psel && penable && pwrite && pready &&
          (paddr >> 2) == APB_AW'(REG_REFERENCE_FREQ))
        a4_ref = pwdata[REF_W-1:0];
    end
    fail_count <= miss_total;
    pending    <= notes_due.size();
  end

endmodule

/* tb/tb_frequency_to_note_octave_unit.sv */
// tb_frequency_to_note_octave_unit: drives frequency beats and reference
// writes into the unit, paces the note sink and gives the verdict.
// Depends on fno_pkg, the channel interfaces, the unit and fno_note_checker.
module tb_frequency_to_note_octave_unit;
  import fno_pkg::*;

  localparam int PIPE_LAT    = int'(LOG_FRAC_BITS_DEF) + 5;
  localparam int PHASE_BEATS = 195;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SPARE_IDX   = 1;       // unmapped register slot
  localparam int N_DIRECTED  = 19;
  localparam int N_SETTINGS  = 8;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  int                fail_count, pending, cycle_count;
  bit                src_gappy, sink_steady;
  int                hold_req_cnt;
  logic [REF_W-1:0]  cur_ref;

  fno_in_if  in_chan();
  fno_out_if out_chan();

  frequency_to_note_octave_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fno_note_checker note_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // pace the note sink: random, steady, or one long hold-off on request
  initial begin : sink_pacing
    int served;
    served = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (served != hold_req_cnt) begin
        served++;
        out_chan.ready <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
      end else if (sink_steady) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // offer one frequency beat, idling first at random, and wait for acceptance
  task automatic push_freq(input logic [FREQ_W-1:0] freq);
    while (src_gappy && $urandom_range(99) < 33) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.frequency <= freq;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // setup then access phase; lands when pready is high
  task automatic reg_write(input int idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx << 2);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, let every note beat drain, then allow the pipe to empty
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // upper word bits carry noise, the register keeps only its own width
  task automatic set_reference(input logic [REF_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = APB_DW'($urandom);
    word[REF_W-1:0] = value;
    reg_write(int'(REG_REFERENCE_FREQ), word);
    cur_ref = value;
  endtask

  // mix of full-range, log-spread and near-rounding-boundary frequencies
  function automatic logic [FREQ_W-1:0] gen_freq(input logic [REF_W-1:0] a4);
    int unsigned       width, pick;
    int                step;
    real               target;
    logic [FREQ_W-1:0] freq;
    pick = $urandom_range(9);
    if (pick == 0) begin
      freq = ($urandom_range(4) == 0) ? '0 : FREQ_W'($urandom);
    end else if (pick <= 5) begin
      width = $urandom_range(FREQ_W, 1);
      freq = FREQ_W'($urandom) & FREQ_W'((64'd1 << width) - 1);
      freq[width-1] = 1'b1;
    end else begin
      // land near a half-semitone point, where rounding decides the note
      step = int'($urandom_range(440)) - 220;
      target = real'((a4 == 0) ? 1 : a4) * (2.0 ** ((real'(step) + 0.5) / 12.0));
      target = target + real'(int'($urandom_range(6)) - 3);
      if (target < 1.0) target = 1.0;
      if (target > 1048575.0) target = 1048575.0;
      freq = FREQ_W'($rtoi(target));
    end
    return freq;
  endfunction

  initial begin : stimulus
    logic [FREQ_W-1:0] directed [N_DIRECTED];
    logic [REF_W-1:0]  settings [N_SETTINGS];
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_chan.valid     = 1'b0;
    in_chan.frequency = '0;
    src_gappy         = 1'b1;
    sink_steady       = 1'b0;
    hold_req_cnt      = 0;
    cur_ref           = REF_RESET;
    // zero, extremes, A in three octaves, every pitch class of octave four,
    // and two values just below the rounding point above A4
    directed = '{20'd0, 20'd1, 20'hFFFFF, 20'd112640, 20'd225280, 20'd56320,
                 20'd66977, 20'd70958, 20'd75177, 20'd79649, 20'd84385,
                 20'd89402, 20'd94717, 20'd100351, 20'd106317, 20'd119338,
                 20'd126434, 20'd115923, 20'd115924};
    settings = '{REF_RESET, 18'd25600, 18'd256000, 18'd0, 18'd1, 18'h3FFFF,
                 18'd25600, 18'd0};
    settings[6] = REF_W'($urandom_range(256000, 25600));
    settings[7] = REF_W'($urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats against the reset reference
    foreach (directed[i]) push_freq(directed[i]);
    wait_idle();
    // a write to the unmapped slot must leave A4 where it was
    reg_write(SPARE_IDX, APB_DW'(0));
    push_freq(20'd112640);

    // random beats under each reference; first phase runs without gaps,
    // the third holds the sink off long enough to back up the input
    for (int p = 0; p < N_SETTINGS; p++) begin
      wait_idle();
      set_reference(settings[p]);
      src_gappy = (p != 0);
      sink_steady <= (p == 0);
      if (p == 2) hold_req_cnt <= hold_req_cnt + 1;
      for (int k = 0; k < PHASE_BEATS; k++) push_freq(gen_freq(cur_ref));
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
